>>> hw/rtl/psc_pkg.sv
// Shared types for the palindromic substring counter.
package psc_pkg;

  localparam int unsigned SymbolW = 8;
  localparam int unsigned CountW  = 15;
  localparam int unsigned CountMax = 32767;

  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    logic               last_symbol;
  } in_beat_t;

  typedef struct packed {
    logic [CountW-1:0] palindrome_count;
    logic              length_exceeded;
  } out_beat_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic shift;  // new symbol enters the history line
    logic clear;  // end of string: drop history and palindrome bits
  } cell_ctrl_t;

endpackage

>>> hw/rtl/psc_cell.sv
// One history cell: holds a symbol, its valid bit, a palindrome-end bit and a partial sum.
module psc_cell #(
  parameter int unsigned SYM_W = 8,
  parameter int unsigned SUM_W = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psc_pkg::cell_ctrl_t  ctrl_i,
  input  logic [SYM_W-1:0]     sym_new_i,
  input  logic                 inner_i,
  input  logic [SYM_W-1:0]     sym_prev_i,
  input  logic                 valid_prev_i,
  input  logic [SUM_W-1:0]     sum_prev_i,
  output logic [SYM_W-1:0]     sym_o,
  output logic                 valid_o,
  output logic                 pal_o,
  output logic [SUM_W-1:0]     sum_o
);

  logic [SYM_W-1:0] sym_q;
  logic             valid_q, valid_d;
  logic             pal_q, pal_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             hit;

  // Palindrome of this cell's length ends at the new symbol.
  assign hit = ctrl_i.shift & valid_q & (sym_q == sym_new_i) & inner_i;

  always_comb begin
    sum_d   = sum_prev_i + SUM_W'(hit);
    valid_d = valid_q;
    pal_d   = pal_q;
    if (ctrl_i.shift) begin
      valid_d = valid_prev_i;
      pal_d   = hit;
    end
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
      pal_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pal_q   <= 1'b0;
      sum_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pal_q   <= pal_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      sym_q <= sym_prev_i;
    end
  end

  assign sym_o   = sym_q;
  assign valid_o = valid_q;
  assign pal_o   = pal_q;
  assign sum_o   = sum_q;

endmodule

>>> hw/rtl/palindromic_substring_counter.sv
// Top level: chain of history cells, sum drain and result register.
//
//  channel | direction | signals                       | beat
//  --------+-----------+-------------------------------+---------------------------
//  in      | input     | in_valid_i/in_ready_o         | in_data_i  (in_beat_t)
//  out     | output    | out_valid_o/out_ready_i       | out_data_o (out_beat_t)
//
// Cycles: one symbol beat per cycle while a string streams in. The beat marked
// last is followed by a drain whose length is set by the length of the cell
// chain that carries partial sums to the accumulator; in_ready_o is low then.
// Reset clears all cells, the accumulator and the result register; no sweep.
// A result waiting on out_ready_i does not block the next string, only the
// end of that next string's drain.
module palindromic_substring_counter #(
  parameter int unsigned MAX_LEN     = 256,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psc_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psc_pkg::out_beat_t  out_data_o
);

  // Only the low bits of the symbol field take part in the compare.
  localparam int unsigned SymW =
      (SYMBOL_BITS < psc_pkg::SymbolW) ? SYMBOL_BITS : psc_pkg::SymbolW;
  // A partial sum entering at cell 1 grows by at most one per cell.
  localparam int unsigned SumW = $clog2(MAX_LEN + 1);
  localparam int unsigned CntW = $clog2(MAX_LEN + 2);
  localparam int unsigned AccW = psc_pkg::CountW + 1;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e                    state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [psc_pkg::CountW-1:0] acc_q, acc_d;
  logic                      ovf_q, ovf_d;
  logic                      out_valid_q, out_valid_d;
  psc_pkg::out_beat_t        out_data_q, out_data_d;

  logic                      accept;
  logic                      full;
  logic                      load_out;
  logic [AccW-1:0]           acc_sum;
  logic [SymW-1:0]           sym_new;
  psc_pkg::cell_ctrl_t       ctrl;

  // Cell links; index 0 is the feed into cell 1.
  logic [SymW-1:0] sym_w   [MAX_LEN+1];
  logic            valid_w [MAX_LEN+1];
  logic [SumW-1:0] sum_w   [MAX_LEN+1];
  logic            pal_w   [MAX_LEN+1];

  assign in_ready_o = (state_q == ST_RUN);
  assign accept     = in_valid_i & in_ready_o;
  // Last cell valid means MAX_LEN symbols are held.
  assign full       = valid_w[MAX_LEN];
  assign sym_new    = in_data_i.symbol[SymW-1:0];

  assign ctrl.shift = accept & ~full;
  assign ctrl.clear = accept & in_data_i.last_symbol;

  assign sym_w[0]   = sym_new;
  assign valid_w[0] = 1'b1;
  assign sum_w[0]   = '0;
  assign pal_w[0]   = 1'b1;

  // Cell k holds the symbol k places back and the palindrome-end bit for
  // length k+1. Length k+1 needs length k-1 at the previous symbol, which
  // lives in cell k-2; lengths zero and one always count as palindromes.
  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    logic inner;
    if (k <= 2) begin : g_short
      assign inner = 1'b1;
    end else begin : g_long
      assign inner = pal_w[k-2];
    end

    psc_cell #(
      .SYM_W (SymW),
      .SUM_W (SumW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .sym_new_i    (sym_new),
      .inner_i      (inner),
      .sym_prev_i   (sym_w[k-1]),
      .valid_prev_i (valid_w[k-1]),
      .sum_prev_i   (sum_w[k-1]),
      .sym_o        (sym_w[k]),
      .valid_o      (valid_w[k]),
      .pal_o        (pal_w[k]),
      .sum_o        (sum_w[k])
    );
  end

  // Sums leaving the chain fold into a saturating accumulator every cycle.
  assign acc_sum  = AccW'(acc_q) + AccW'(sum_w[MAX_LEN]);
  assign load_out = (state_q == ST_DRAIN) && (cnt_q == CntW'(MAX_LEN)) &&
                    (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    acc_d       = (acc_sum > AccW'(psc_pkg::CountMax)) ?
                  psc_pkg::CountW'(psc_pkg::CountMax) : acc_sum[psc_pkg::CountW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_RUN: begin
        if (accept && full) begin
          ovf_d = 1'b1;
        end
        if (accept && in_data_i.last_symbol) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        if (cnt_q != CntW'(MAX_LEN)) begin
          cnt_d = cnt_q + CntW'(1);
        end else if (load_out) begin
          // Chain is flushed: acc_q holds the whole string's count.
          out_valid_d                 = 1'b1;
          out_data_d.palindrome_count = acc_q;
          out_data_d.length_exceeded  = ovf_q;
          acc_d                       = '0;
          ovf_d                       = 1'b0;
          state_d                     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // End of string drops the history at once.
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.last_symbol) |=> (!valid_w[1] && !in_ready_o))
    else $error("history not cleared or drain not started after last beat");

  // History fills from the front: a full line has its first cell valid.
  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> valid_w[1])
    else $error("history line filled out of order");

  // A result appears only at the end of a drain.
  a_out_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DRAIN))
    else $error("result raised outside drain");

  // Chain is empty when the result is taken from the accumulator.
  a_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (sum_w[MAX_LEN] == '0))
    else $error("partial sums still in flight at result load");

endmodule

>>> verif/palindromic_substring_counter_tb.sv
// Self-checking testbench for the palindromic substring counter.
`timescale 1ns / 1ps

module palindromic_substring_counter_tb;

  localparam int unsigned MAX_LEN     = 256;
  localparam int unsigned SYMBOL_BITS = 8;
  localparam int unsigned RAND_ITEMS  = 1600;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned MAX_SHOWN   = 10;

  // Flavors of generated strings.
  localparam int unsigned STR_RANDOM = 0;  // full symbol range, few palindromes
  localparam int unsigned STR_PAIR   = 1;  // two-symbol alphabet, many palindromes
  localparam int unsigned STR_MIRROR = 2;  // whole string is a palindrome
  localparam int unsigned STR_SAME   = 3;  // one symbol repeated, maximum count

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  psc_pkg::in_beat_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  psc_pkg::out_beat_t out_data_o;

  palindromic_substring_counter #(
    .MAX_LEN    (MAX_LEN),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Stimulus and expectations.
  psc_pkg::in_beat_t  pending_beats[$];
  psc_pkg::out_beat_t expected_counts[$];
  int unsigned err_total = 0;
  int unsigned cycle_cnt = 0;

  // Handshake bookkeeping for the driver; in_taken comes from the monitor.
  logic        in_taken   = 1'b0;  // input beat accepted at the last rising edge
  int unsigned src_hold   = 0;
  int unsigned snk_hold   = 0;
  int unsigned idle_pct   = 0;
  int unsigned phase_cnt  = 0;

  // Predictor state: mirrors what the chain of history cells holds.
  logic [SYMBOL_BITS-1:0] seen_syms[MAX_LEN];
  bit                     pal_ends_here[MAX_LEN+1];
  int unsigned            str_pos    = 0;
  int unsigned            pal_total  = 0;
  bit                     truncated  = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------
  task automatic clear_string();
    for (int i = 0; i <= MAX_LEN; i++) pal_ends_here[i] = 1'b0;
    str_pos   = 0;
    pal_total = 0;
    truncated = 1'b0;
  endtask

  // A palindrome of length len ends at the new symbol when the symbol len-1
  // back matches and one of length len-2 ended at the previous symbol. Walk
  // lengths downward so bit len-2 still holds the previous symbol's value.
  task automatic absorb_symbol(input logic [SYMBOL_BITS-1:0] sym);
    int unsigned added;
    bit          inner_ok;
    bit          hit;
    added = 0;
    for (int unsigned len = str_pos + 1; len >= 2; len--) begin
      inner_ok = (len - 2 < 2) ? 1'b1 : pal_ends_here[len-2];
      hit      = (seen_syms[str_pos-(len-1)] == sym) && inner_ok;
      pal_ends_here[len] = hit;
      if (hit) added++;
    end
    pal_ends_here[0] = 1'b1;
    pal_ends_here[1] = 1'b1;
    seen_syms[str_pos] = sym;
    str_pos++;
    pal_total += added;
    if (pal_total > psc_pkg::CountMax) pal_total = psc_pkg::CountMax;
  endtask

  task automatic track_symbol_beat(input psc_pkg::in_beat_t beat);
    psc_pkg::out_beat_t res;
    // Past MAX_LEN the symbol is dropped, only the flag remembers it.
    if (str_pos < MAX_LEN) absorb_symbol(beat.symbol);
    else truncated = 1'b1;
    if (beat.last_symbol) begin
      res.palindrome_count = pal_total[psc_pkg::CountW-1:0];
      res.length_exceeded  = truncated;
      expected_counts.insert(expected_counts.size(), res);
      clear_string();
    end
  endtask

  //--------------------------------------------------------------------------
  // Checking
  //--------------------------------------------------------------------------
  task automatic report_miss(input string what, input psc_pkg::out_beat_t want,
                             input psc_pkg::out_beat_t got);
    err_total++;
    if (err_total <= MAX_SHOWN)
      $display("%0t: %s: exp count=%0d exceeded=%0b, got count=%0d exceeded=%0b",
               $realtime, what, want.palindrome_count, want.length_exceeded,
               got.palindrome_count, got.length_exceeded);
  endtask

  task automatic check_result(input psc_pkg::out_beat_t got);
    psc_pkg::out_beat_t want;
    if (expected_counts.size() == 0) begin
      report_miss("result beat with nothing expected", '0, got);
    end else begin
      want = expected_counts.pop_front();
      if (got.palindrome_count !== want.palindrome_count ||
          got.length_exceeded !== want.length_exceeded)
        report_miss("result mismatch", want, got);
    end
  endtask

  // Monitor: everything sampled at the rising edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) track_symbol_beat(in_data_i);
      if (out_valid_o && out_ready_i) check_result(out_data_o);
    end
  end

  //--------------------------------------------------------------------------
  // Driver: all inputs change at the falling edge, one assignment each.
  //--------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_beats
    logic              nxt_valid;
    logic              nxt_ready;
    psc_pkg::in_beat_t nxt_beat;
    nxt_valid = in_valid_i;
    nxt_ready = out_ready_i;
    nxt_beat  = in_data_i;
    if (rst_ni) begin
      // Idle density changes in phases; the tail of the run has none.
      phase_cnt++;
      if (phase_cnt % 64 == 0) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (pending_beats.size() < 150) idle_pct = 0;

      // Sender: a beat on the bus holds until it is taken.
      if (!in_valid_i || in_taken) begin
        if (src_hold > 0) begin
          nxt_valid = 1'b0;
          src_hold--;
        end else if (pending_beats.size() == 0) begin
          nxt_valid = 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          nxt_valid = 1'b0;
          src_hold  = $urandom_range(2);  // start an idle burst
        end else begin
          nxt_valid = 1'b1;
          nxt_beat  = pending_beats.pop_front();
        end
      end

      // Receiver: stall bursts independent of out_valid_o.
      if (snk_hold > 0) begin
        nxt_ready = 1'b0;
        snk_hold--;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        nxt_ready = 1'b0;
        snk_hold  = $urandom_range(2);
      end else begin
        nxt_ready = 1'b1;
      end
    end
    in_valid_i  <= nxt_valid;
    out_ready_i <= nxt_ready;
    in_data_i   <= nxt_beat;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus
  //--------------------------------------------------------------------------
  task automatic push_beat(input logic [SYMBOL_BITS-1:0] sym, input logic last);
    psc_pkg::in_beat_t beat;
    beat.symbol      = sym;
    beat.last_symbol = last;
    pending_beats.insert(pending_beats.size(), beat);
  endtask

  // Short fixed string, first symbol in the most significant used byte.
  task automatic push_word(input logic [63:0] w, input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_beat(w[8*(n-1-i) +: 8], i == n - 1);
  endtask

  task automatic push_string(input int unsigned len, input int unsigned flavor);
    logic [SYMBOL_BITS-1:0] sym_a;
    logic [SYMBOL_BITS-1:0] sym_b;
    logic [SYMBOL_BITS-1:0] body[$];
    logic [SYMBOL_BITS-1:0] sym;
    sym_a = SYMBOL_BITS'($urandom_range(255));
    sym_b = SYMBOL_BITS'($urandom_range(255));
    for (int unsigned i = 0; i < len; i++) begin
      case (flavor)
        STR_RANDOM: sym = SYMBOL_BITS'($urandom_range(255));
        STR_PAIR:   sym = $urandom_range(1) ? sym_a : sym_b;
        STR_MIRROR: begin
          // Second half reflects the first; mostly two symbols, some noise.
          if (i >= (len + 1) / 2)      sym = body[len-1-i];
          else if ($urandom_range(9) == 0) sym = SYMBOL_BITS'($urandom_range(255));
          else                         sym = $urandom_range(1) ? sym_a : sym_b;
        end
        default:    sym = sym_a;
      endcase
      body.insert(body.size(), sym);
      push_beat(sym, i == len - 1);
    end
  endtask

  initial begin : run_test
    int unsigned rand_items;
    int unsigned len;
    int unsigned pick;

    clear_string();

    // Directed: one-symbol string, byte extremes, odd and even palindromes,
    // overlapping runs.
    push_word(64'h00, 1);
    push_word(64'hFF_FF, 2);
    push_word(64'h00_FF, 2);
    push_word(64'h61_62_61, 3);
    push_word(64'h61_62_62_61, 4);
    push_word(64'h5A_5A_5A, 3);
    push_word(64'hAA_55_55_AA_55, 5);

    // Longest strings: full history at maximum count, and truncation.
    rand_items = 0;
    push_string(MAX_LEN, STR_SAME);
    push_string(MAX_LEN + 44, STR_SAME);
    push_string(MAX_LEN + 1, STR_MIRROR);
    push_string(MAX_LEN, STR_RANDOM);
    rand_items += 4 * MAX_LEN + 45;

    // Random strings, mostly short so many results come back.
    while (rand_items < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 88)      len = $urandom_range(24, 1);
      else if (pick < 98) len = $urandom_range(90, 25);
      else                len = $urandom_range(MAX_LEN + 40, MAX_LEN - 40);
      pick = $urandom_range(9);
      if (pick < 2)       push_string(len, STR_RANDOM);
      else if (pick < 6)  push_string(len, STR_PAIR);
      else if (pick < 9)  push_string(len, STR_MIRROR);
      else                push_string(len, STR_SAME);
      rand_items += len;
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_counts.size() != 0) @(posedge clk_i);
    // Let the drain chain run out to catch stray result beats.
    repeat (MAX_LEN + 16) @(posedge clk_i);

    if (err_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> palindromic_substring_counter.f
hw/rtl/psc_pkg.sv
hw/rtl/psc_cell.sv
hw/rtl/palindromic_substring_counter.sv
verif/palindromic_substring_counter_tb.sv
